>>> sv/elm_pkg.sv
package elm_pkg;

    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int NW         = $clog2(RING_DEPTH + 1);
    localparam int LAG_W      = 20;
    localparam int SUM_W      = LAG_W + NW;
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 7;
    localparam int CNT_OUT_W  = 7;

    // (9*old + new + 5) / 10 by reciprocal, exact below 2^26
    localparam int          SMX_W      = 24;
    localparam int          RECIP10_SH = 27;
    localparam logic [23:0] RECIP10    = 24'd13421773;

    // ceil(n*pct/100) by reciprocal, exact below about 2^17
    localparam int          RK_W        = NW + PCT_W;
    localparam int          RECIP100_SH = 24;
    localparam logic [17:0] RECIP100    = 18'd167773;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;

    localparam logic [2:0] SRC_LEFT   = 3'd0;
    localparam logic [2:0] SRC_RIGHT  = 3'd1;
    localparam logic [2:0] SRC_AXIS_X = 3'd2;
    localparam logic [2:0] SRC_AXIS_Y = 3'd3;

    localparam logic [2:0] ACT_PRESSED = 3'd0;
    localparam logic [2:0] ACT_REPEAT  = 3'd2;
    localparam logic [2:0] ACT_AXIS    = 3'd4;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PCT    = 2'd2;

    typedef struct packed {
        logic             enable;
        logic [LAG_W-1:0] limit;
        logic [PCT_W-1:0] pct;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic update;
        logic mul;
        logic smooth;
        logic clear_stats;
        logic scan_run;
        logic rank1;
        logic rank2;
        logic next_pass;
        logic found;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic hit;
        logic n_zero;
        logic div_busy;
    } t_status;

endpackage

>>> sv/elm_div.sv
module elm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [elm_pkg::SUM_W-1:0]   i_dividend,
    input  logic [elm_pkg::NW-1:0]      i_divisor,
    output logic                        o_busy,
    output logic [elm_pkg::SUM_W-1:0]   o_quotient
);

    localparam int CW = $clog2(elm_pkg::SUM_W + 1);

    logic [CW-1:0]              r_cnt;
    logic [elm_pkg::SUM_W-1:0]  r_quo;
    logic [elm_pkg::NW-1:0]     r_rem;
    logic [elm_pkg::NW-1:0]     r_div;
    logic [elm_pkg::NW:0]       trial;
    logic                       take;

    assign trial = {r_rem, r_quo[elm_pkg::SUM_W-1]};
    assign take  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(elm_pkg::SUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[elm_pkg::SUM_W-2:0], take};
            r_rem <= take ? elm_pkg::NW'(trial - {1'b0, r_div}) : elm_pkg::NW'(trial);
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

>>> sv/elm_ctrl.sv
module elm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  elm_pkg::t_status   i_status,
    output elm_pkg::t_cmd      o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_UPD   = 11'b000_0000_0010,
        S_MUL   = 11'b000_0000_0100,
        S_SMT   = 11'b000_0000_1000,
        S_SCAN  = 11'b000_0001_0000,
        S_DRAIN = 11'b000_0010_0000,
        S_RK1   = 11'b000_0100_0000,
        S_RK2   = 11'b000_1000_0000,
        S_CHK   = 11'b001_0000_0000,
        S_WDIV  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SMT;
            end
            S_SMT: begin
                o_cmd.smooth      = 1'b1;
                o_cmd.clear_stats = 1'b1;
                n_state           = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RK1;
            end
            S_RK1: begin
                o_cmd.rank1 = 1'b1;
                n_state     = S_RK2;
            end
            S_RK2: begin
                o_cmd.rank2 = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_status.n_zero || i_status.hit) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_WDIV;
                end else begin
                    o_cmd.next_pass = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_WDIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/elm_dp.sv
module elm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  elm_pkg::t_cfg                 i_cfg,
    input  elm_pkg::t_cmd                 i_cmd,
    output elm_pkg::t_status              o_status,
    input  logic [1:0]                    i_kind,
    input  logic [elm_pkg::TIME_W-1:0]    i_now_us,
    input  logic [elm_pkg::TIME_W-1:0]    i_frame_number,
    input  logic [2:0]                    i_source,
    input  logic [2:0]                    i_action,
    output logic                          o_stored,
    output logic                          o_pending,
    output logic [elm_pkg::LAG_W-1:0]     o_raw_us,
    output logic [elm_pkg::LAG_W-1:0]     o_smoothed_us,
    output logic [elm_pkg::LAG_W-1:0]     o_average_us,
    output logic [elm_pkg::LAG_W-1:0]     o_minimum_us,
    output logic [elm_pkg::LAG_W-1:0]     o_maximum_us,
    output logic [elm_pkg::LAG_W-1:0]     o_percentile_us,
    output logic [elm_pkg::LAG_W-1:0]     o_last_us,
    output logic [elm_pkg::CNT_OUT_W-1:0] o_valid_count
);

    localparam int AW = elm_pkg::ADDR_W;
    localparam int LW = elm_pkg::LAG_W;
    localparam int NW = elm_pkg::NW;
    localparam int TW = elm_pkg::TIME_W;

    // captured beat
    logic [1:0]    r_kind;
    logic [TW-1:0] r_now;
    logic [TW-1:0] r_frame;
    logic [2:0]    r_src;
    logic [2:0]    r_act;

    // measurement state
    logic          r_waiting;
    logic [TW-1:0] r_start_time;
    logic [TW-1:0] r_start_frame;
    logic [LW-1:0] r_raw;
    logic [LW-1:0] r_smooth;
    logic [LW-1:0] r_last;
    logic [AW-1:0] r_wp;
    logic          r_stored;
    logic          r_sm_pend;
    logic [elm_pkg::SMX_W-1:0]    r_sm_x;
    logic [elm_pkg::SMX_W+23:0]   r_sm_prod;

    // ring
    logic [LW-1:0]         r_ring [elm_pkg::RING_DEPTH];
    logic [elm_pkg::RING_DEPTH-1:0] r_ring_vld;
    logic [AW-1:0]         r_addr;
    logic [LW-1:0]         r_rdata;
    logic                  r_rvld;
    logic                  r_rd_d;

    // statistics
    logic                      r_pass0;
    logic [elm_pkg::SUM_W-1:0] r_sum;
    logic [NW-1:0]             r_n;
    logic [LW-1:0]             r_max;
    logic [LW-1:0]             r_min;
    logic [LW-1:0]             r_prev;
    logic [LW-1:0]             r_best;
    logic [NW-1:0]             r_cnt;
    logic [NW-1:0]             r_cum;
    logic [elm_pkg::RK_W-1:0]  r_rkx;
    logic [NW-1:0]             r_rank;
    logic [LW-1:0]             r_pval;

    logic          tracked;
    logic [TW-1:0] lag;
    logic          lag_ok;
    logic          eof_fire;
    logic [elm_pkg::PCT_W-1:0]      pct_c;
    logic [elm_pkg::RK_W+17:0]      rk_prod;
    logic [NW-1:0]                  rk_q;
    logic [NW-1:0]                  rk_r;
    logic                           div_busy;
    logic [elm_pkg::SUM_W-1:0]      quotient;
    logic [elm_pkg::SUM_W-1:0]      dividend;

    function automatic logic i_src_is_button(input logic [2:0] src);
        return src == elm_pkg::SRC_LEFT || src == elm_pkg::SRC_RIGHT;
    endfunction

    assign tracked = ((i_src_is_button(r_src)) &&
                      (r_act == elm_pkg::ACT_PRESSED || r_act == elm_pkg::ACT_REPEAT)) ||
                     ((r_src == elm_pkg::SRC_AXIS_X || r_src == elm_pkg::SRC_AXIS_Y) &&
                      r_act == elm_pkg::ACT_AXIS);

    assign lag      = r_now - r_start_time;
    assign lag_ok   = (lag != '0) && (lag < TW'(i_cfg.limit));
    assign eof_fire = (r_kind == elm_pkg::KIND_EOF) && r_waiting && (r_frame > r_start_frame);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_now   <= i_now_us;
            r_frame <= i_frame_number;
            r_src   <= i_source;
            r_act   <= i_action;
        end
    end

    // event and end-of-frame handling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting     <= 1'b0;
            r_start_time  <= '0;
            r_start_frame <= '0;
            r_raw         <= '0;
            r_smooth      <= '0;
            r_last        <= '0;
            r_wp          <= '0;
            r_stored      <= 1'b0;
            r_sm_pend     <= 1'b0;
        end else if (i_cmd.update) begin
            r_stored  <= 1'b0;
            r_sm_pend <= 1'b0;
            if (r_kind == elm_pkg::KIND_EVENT) begin
                if (i_cfg.enable && !r_waiting && tracked) begin
                    r_start_time  <= r_now;
                    r_start_frame <= r_frame;
                    r_waiting     <= 1'b1;
                end
            end else if (eof_fire) begin
                if (lag_ok) begin
                    r_raw    <= lag[LW-1:0];
                    r_last   <= lag[LW-1:0];
                    r_stored <= 1'b1;
                    r_wp     <= (r_wp == AW'(elm_pkg::RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    if (r_smooth == '0) begin
                        r_smooth <= lag[LW-1:0];
                    end else begin
                        r_sm_pend <= 1'b1;
                    end
                end
                r_waiting     <= 1'b0;
                r_start_time  <= '0;
                r_start_frame <= '0;
            end
        end else if (i_cmd.smooth && r_sm_pend) begin
            r_smooth <= r_sm_prod[elm_pkg::RECIP10_SH +: LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_sm_x <= elm_pkg::SMX_W'({r_smooth, 3'b000}) + elm_pkg::SMX_W'(r_smooth)
                    + elm_pkg::SMX_W'(lag[LW-1:0]) + elm_pkg::SMX_W'(5);
        end
        if (i_cmd.mul) begin
            r_sm_prod <= r_sm_x * elm_pkg::RECIP10;
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && eof_fire && lag_ok) begin
            r_ring[r_wp] <= lag[LW-1:0];
        end
        if (i_cmd.scan_run) begin
            r_rdata <= r_ring[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_addr     <= '0;
            r_rd_d     <= 1'b0;
            r_rvld     <= 1'b0;
        end else begin
            if (i_cmd.update && eof_fire && lag_ok) begin
                r_ring_vld[r_wp] <= 1'b1;
            end
            r_rd_d <= i_cmd.scan_run;
            if (i_cmd.scan_run) begin
                r_rvld <= r_ring_vld[r_addr];
                r_addr <= o_status.last_addr ? '0 : r_addr + 1'b1;
            end
        end
    end

    // scan accumulation: pass 0 gathers sum, count, max; every pass finds
    // the next distinct value above r_prev and its multiplicity
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_stats) begin
            r_pass0 <= 1'b1;
            r_sum   <= '0;
            r_n     <= '0;
            r_max   <= '0;
            r_cum   <= '0;
            r_prev  <= '0;
            r_best  <= '1;
            r_cnt   <= '0;
        end else if (i_cmd.next_pass) begin
            r_pass0 <= 1'b0;
            r_cum   <= r_cum + r_cnt;
            r_prev  <= r_best;
            r_best  <= '1;
            r_cnt   <= '0;
        end else if (r_rd_d && r_rvld) begin
            if (r_pass0) begin
                r_sum <= r_sum + elm_pkg::SUM_W'(r_rdata);
                r_n   <= r_n + 1'b1;
                if (r_rdata > r_max) begin
                    r_max <= r_rdata;
                end
            end
            if (r_rdata > r_prev) begin
                if (r_rdata < r_best) begin
                    r_best <= r_rdata;
                    r_cnt  <= NW'(1);
                end else if (r_rdata == r_best) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign pct_c   = (i_cfg.pct > elm_pkg::PCT_MAX) ? elm_pkg::PCT_MAX : i_cfg.pct;
    assign rk_prod = r_rkx * elm_pkg::RECIP100;
    assign rk_q    = rk_prod[elm_pkg::RECIP100_SH +: NW];
    assign rk_r    = (rk_q == '0) ? '0 : rk_q - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank1) begin
            r_rkx <= elm_pkg::RK_W'(r_n) * elm_pkg::RK_W'(pct_c) + elm_pkg::RK_W'(99);
        end
        // minimum is the first distinct value, known only after pass 0
        if (i_cmd.rank1 && r_pass0) begin
            r_min <= (r_n == '0) ? '0 : r_best;
        end
        if (i_cmd.rank2) begin
            r_rank <= (rk_r > r_n - 1'b1) ? r_n - 1'b1 : rk_r;
        end
        if (i_cmd.found) begin
            r_pval <= (r_n == '0) ? '0 : r_best;
        end
    end

    assign dividend = r_sum + elm_pkg::SUM_W'(r_n >> 1);

    elm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rank2 && r_pass0),
        .i_dividend (dividend),
        .i_divisor  (r_n),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign o_status.last_addr = r_addr == AW'(elm_pkg::RING_DEPTH - 1);
    assign o_status.hit       = ({1'b0, r_cum} + {1'b0, r_cnt}) > {1'b0, r_rank};
    assign o_status.n_zero    = r_n == '0;
    assign o_status.div_busy  = div_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_stored        <= r_stored;
            o_pending       <= r_waiting;
            o_raw_us        <= r_raw;
            o_smoothed_us   <= r_smooth;
            o_average_us    <= (r_n == '0) ? '0 : quotient[LW-1:0];
            o_minimum_us    <= r_min;
            o_maximum_us    <= r_max;
            o_percentile_us <= r_pval;
            o_last_us       <= r_last;
            o_valid_count   <= elm_pkg::CNT_OUT_W'(r_n);
        end
    end

endmodule

>>> sv/event_latency_monitor.sv
// Event latency monitor: lag from a tracked input event to the next frame end.
// Input channel (i_in_valid / o_in_stall): one beat per item, kind selects an
// input event, an end of frame or a stats query. A beat is taken when valid is
// high and stall low; stall is high from the accepting edge until the item's
// result has been loaded into the output register.
// Output channel (o_out_valid / i_out_stall): one beat per item with the full
// statistics. The output register holds a beat while the receiver stalls, and
// the next item is accepted and worked on meanwhile; it finishes only once the
// waiting beat has gone.
// Sequence: update and smoothing, then a scan of the 64-entry ring and rank
// work; every further distinct sample value below the percentile rank costs
// another selection pass over the single ring read port. The mean divider
// starts after the first pass and runs alongside later passes. For an empty or
// single-valued ring the divider bounds the time from accept to output valid.
// Reset: synchronous; clears the measurement, the ring valid bits (no clearing
// pass needed) and restores enable 0, limit 1000000 us, percentile 95.
// APB: registers at 0x0 enable, 0x4 lag limit, 0x8 percentile; pready tied high.
module event_latency_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [elm_pkg::TIME_W-1:0]     i_now_us,
    input  logic [elm_pkg::TIME_W-1:0]     i_frame_number,
    input  logic [2:0]                     i_source,
    input  logic [2:0]                     i_action,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_stored,
    output logic                           o_pending,
    output logic [elm_pkg::LAG_W-1:0]      o_raw_us,
    output logic [elm_pkg::LAG_W-1:0]      o_smoothed_us,
    output logic [elm_pkg::LAG_W-1:0]      o_average_us,
    output logic [elm_pkg::LAG_W-1:0]      o_minimum_us,
    output logic [elm_pkg::LAG_W-1:0]      o_maximum_us,
    output logic [elm_pkg::LAG_W-1:0]      o_percentile_us,
    output logic [elm_pkg::LAG_W-1:0]      o_last_us,
    output logic [elm_pkg::CNT_OUT_W-1:0]  o_valid_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    elm_pkg::t_cfg    r_cfg;
    elm_pkg::t_cmd    cmd;
    elm_pkg::t_status status;
    logic [1:0]       reg_idx;
    logic             cfg_wr;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.limit  <= 20'd1000000;
            r_cfg.pct    <= 7'd95;
        end else if (cfg_wr) begin
            priority case (reg_idx)
                elm_pkg::REG_ENABLE: r_cfg.enable <= pwdata[0];
                elm_pkg::REG_LIMIT:  r_cfg.limit  <= pwdata[elm_pkg::LAG_W-1:0];
                elm_pkg::REG_PCT:    r_cfg.pct    <= pwdata[elm_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority case (reg_idx)
            elm_pkg::REG_ENABLE: prdata = {31'b0, r_cfg.enable};
            elm_pkg::REG_LIMIT:  prdata = 32'(r_cfg.limit);
            elm_pkg::REG_PCT:    prdata = 32'(r_cfg.pct);
            default:             prdata = '0;
        endcase
    end

    // ---- sequencer ----
    elm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // ---- datapath: measurement, ring, statistics, output register ----
    elm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_kind),
        .i_now_us        (i_now_us),
        .i_frame_number  (i_frame_number),
        .i_source        (i_source),
        .i_action        (i_action),
        .o_stored        (o_stored),
        .o_pending       (o_pending),
        .o_raw_us        (o_raw_us),
        .o_smoothed_us   (o_smoothed_us),
        .o_average_us    (o_average_us),
        .o_minimum_us    (o_minimum_us),
        .o_maximum_us    (o_maximum_us),
        .o_percentile_us (o_percentile_us),
        .o_last_us       (o_last_us),
        .o_valid_count   (o_valid_count)
    );

    // ---- checks ----
    // an accepted beat keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after accept");

    // a stored sample is nonzero and is the newest ring entry
    a_stored_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stored |-> o_raw_us != '0 && o_raw_us == o_last_us)
        else $error("stored sample inconsistent");

    // empty ring iff zero maximum
    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_count == '0) == (o_maximum_us == '0))
        else $error("count and maximum disagree");

    // percentile lies between minimum and maximum
    a_pct_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_minimum_us <= o_percentile_us && o_percentile_us <= o_maximum_us)
        else $error("percentile out of range");

endmodule

>>> tb/event_latency_monitor_tb.sv
module event_latency_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // item kinds and event codes the package leaves out
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [2:0] SRC_OTHER    = 3'd4;
    localparam logic [2:0] ACT_RELEASED = 3'd1;
    localparam logic [2:0] ACT_DOUBLE   = 3'd3;

    localparam int LONG_HOLD_CYC = 3000;
    localparam int SETTLE_CYC    = 20;
    localparam int TAIL_CYC      = 200;

    typedef struct {
        logic [1:0]                 kind;
        logic [elm_pkg::TIME_W-1:0] now_us;
        logic [elm_pkg::TIME_W-1:0] frame;
        logic [2:0]                 source;
        logic [2:0]                 action;
    } event_beat_t;

    typedef struct {
        logic                          stored;
        logic                          pending;
        logic [elm_pkg::LAG_W-1:0]     raw_us;
        logic [elm_pkg::LAG_W-1:0]     smoothed_us;
        logic [elm_pkg::LAG_W-1:0]     average_us;
        logic [elm_pkg::LAG_W-1:0]     minimum_us;
        logic [elm_pkg::LAG_W-1:0]     maximum_us;
        logic [elm_pkg::LAG_W-1:0]     percentile_us;
        logic [elm_pkg::LAG_W-1:0]     last_us;
        logic [elm_pkg::CNT_OUT_W-1:0] valid_count;
    } lag_stats_t;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_kind = '0;
    logic [elm_pkg::TIME_W-1:0]     i_now_us = '0;
    logic [elm_pkg::TIME_W-1:0]     i_frame_number = '0;
    logic [2:0]                     i_source = '0;
    logic [2:0]                     i_action = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_stored;
    logic                           o_pending;
    logic [elm_pkg::LAG_W-1:0]      o_raw_us;
    logic [elm_pkg::LAG_W-1:0]      o_smoothed_us;
    logic [elm_pkg::LAG_W-1:0]      o_average_us;
    logic [elm_pkg::LAG_W-1:0]      o_minimum_us;
    logic [elm_pkg::LAG_W-1:0]      o_maximum_us;
    logic [elm_pkg::LAG_W-1:0]      o_percentile_us;
    logic [elm_pkg::LAG_W-1:0]      o_last_us;
    logic [elm_pkg::CNT_OUT_W-1:0]  o_valid_count;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [3:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    event_latency_monitor uut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Shadow of the monitor: registers, measurement and lag ring
    // ---------------------------------------------------------------------
    logic                         cfg_enable = 1'b0;
    logic [elm_pkg::LAG_W-1:0]    cfg_limit  = 20'd1000000;
    logic [elm_pkg::PCT_W-1:0]    cfg_pct    = 7'd95;

    logic                         meas_waiting = 1'b0;
    logic [elm_pkg::TIME_W-1:0]   meas_time    = '0;
    logic [elm_pkg::TIME_W-1:0]   meas_frame   = '0;
    logic [elm_pkg::LAG_W-1:0]    lag_raw      = '0;
    logic [elm_pkg::LAG_W-1:0]    lag_smooth   = '0;
    logic [elm_pkg::LAG_W-1:0]    lag_ring [elm_pkg::RING_DEPTH];
    logic [elm_pkg::ADDR_W-1:0]   ring_wr      = '0;

    event_beat_t pending_beats[$];
    lag_stats_t  expected_stats[$];
    int          fail_count = 0;

    initial foreach (lag_ring[k]) lag_ring[k] = '0;

    function automatic bit tracked_event(logic [2:0] src, logic [2:0] act);
        if ((src == elm_pkg::SRC_LEFT || src == elm_pkg::SRC_RIGHT) &&
            (act == elm_pkg::ACT_PRESSED || act == elm_pkg::ACT_REPEAT))
            return 1'b1;
        return (src == elm_pkg::SRC_AXIS_X || src == elm_pkg::SRC_AXIS_Y) &&
               act == elm_pkg::ACT_AXIS;
    endfunction

    // Advance the shadow by one beat and return the statistics it should report
    function automatic lag_stats_t predict_stats(event_beat_t b);
        lag_stats_t      r;
        logic [31:0]     lag;
        int unsigned     samples[$];
        longint unsigned total;
        int unsigned     n, pct, rank;
        r = '{default: '0};
        if (b.kind == elm_pkg::KIND_EVENT) begin
            if (cfg_enable && !meas_waiting && tracked_event(b.source, b.action)) begin
                meas_time    = b.now_us;
                meas_frame   = b.frame;
                meas_waiting = 1'b1;
            end
        end else if (b.kind == elm_pkg::KIND_EOF && meas_waiting && b.frame > meas_frame) begin
            lag = b.now_us - meas_time;
            if (lag != 0 && lag < cfg_limit) begin
                lag_raw = lag[elm_pkg::LAG_W-1:0];
                if (lag_smooth == 0)
                    lag_smooth = lag_raw;
                else
                    lag_smooth = elm_pkg::LAG_W'((32'd9 * lag_smooth + lag_raw + 32'd5)
                                                 / 32'd10);
                lag_ring[ring_wr] = lag_raw;
                ring_wr = ring_wr + 1'b1;
                r.stored = 1'b1;
            end
            meas_waiting = 1'b0;
            meas_time    = '0;
            meas_frame   = '0;
        end

        total = 0;
        foreach (lag_ring[k]) begin
            if (lag_ring[k] != 0) begin
                samples.push_back(lag_ring[k]);
                total += lag_ring[k];
            end
        end
        samples.sort();
        n = samples.size();
        if (n > 0) begin
            pct  = (cfg_pct > 100) ? 100 : cfg_pct;
            rank = (n * pct + 99) / 100;
            rank = (rank == 0) ? 0 : rank - 1;
            if (rank > n - 1) rank = n - 1;
            r.average_us    = elm_pkg::LAG_W'((total + n / 2) / n);
            r.minimum_us    = elm_pkg::LAG_W'(samples[0]);
            r.maximum_us    = elm_pkg::LAG_W'(samples[n-1]);
            r.percentile_us = elm_pkg::LAG_W'(samples[rank]);
        end
        r.pending     = meas_waiting;
        r.raw_us      = lag_raw;
        r.smoothed_us = lag_smooth;
        r.last_us     = lag_ring[ring_wr - 1'b1];
        r.valid_count = elm_pkg::CNT_OUT_W'(n);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------
    // Sender: bursts of random length with random gaps; predicts on acceptance
    // ---------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : sender
        event_beat_t nxt, cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cur = '{i_kind, i_now_us, i_frame_number, i_source, i_action};
                expected_stats.push_back(predict_stats(cur));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    i_kind         <= nxt.kind;
                    i_now_us       <= nxt.now_us;
                    i_frame_number <= nxt.frame;
                    i_source       <= nxt.source;
                    i_action       <= nxt.action;
                    i_in_valid     <= 1'b1;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        // a quarter of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus an occasional long hold-off
    // ---------------------------------------------------------------------
    int long_hold_asks = 0;
    int long_hold_seen = 0;
    int long_hold_cnt  = 0;
    int stall_seg      = 0;
    bit stall_level    = 1'b0;

    always @(posedge i_clk) begin : receiver
        if (long_hold_seen != long_hold_asks) begin
            long_hold_seen = long_hold_asks;
            long_hold_cnt  = LONG_HOLD_CYC;
        end
        if (long_hold_cnt > 0) begin
            long_hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_seg == 0) begin
                stall_seg   = $urandom_range(1, 24);
                stall_level = ($urandom_range(0, 2) == 0);
            end
            stall_seg--;
            // mostly a whole segment clear, sometimes a random beat-by-beat pattern
            i_out_stall <= stall_level && ($urandom_range(0, 1) == 1);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: each output beat against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        lag_stats_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_stats.size() == 0) begin
                $display("%0t: output beat with nothing expected", $realtime);
                fail_count++;
            end else begin
                w = expected_stats.pop_front();
                if (o_stored !== w.stored) report_mismatch("stored", o_stored, w.stored);
                if (o_pending !== w.pending) report_mismatch("pending", o_pending, w.pending);
                if (o_raw_us !== w.raw_us) report_mismatch("raw_us", o_raw_us, w.raw_us);
                if (o_smoothed_us !== w.smoothed_us)
                    report_mismatch("smoothed_us", o_smoothed_us, w.smoothed_us);
                if (o_average_us !== w.average_us)
                    report_mismatch("average_us", o_average_us, w.average_us);
                if (o_minimum_us !== w.minimum_us)
                    report_mismatch("minimum_us", o_minimum_us, w.minimum_us);
                if (o_maximum_us !== w.maximum_us)
                    report_mismatch("maximum_us", o_maximum_us, w.maximum_us);
                if (o_percentile_us !== w.percentile_us)
                    report_mismatch("percentile_us", o_percentile_us, w.percentile_us);
                if (o_last_us !== w.last_us) report_mismatch("last_us", o_last_us, w.last_us);
                if (o_valid_count !== w.valid_count)
                    report_mismatch("valid_count", o_valid_count, w.valid_count);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the value at this edge
        case (reg_idx)
            elm_pkg::REG_ENABLE: cfg_enable = value[0];
            elm_pkg::REG_LIMIT:  cfg_limit  = value[elm_pkg::LAG_W-1:0];
            elm_pkg::REG_PCT:    cfg_pct    = value[elm_pkg::PCT_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic en, logic [elm_pkg::LAG_W-1:0] lim,
                              logic [elm_pkg::PCT_W-1:0] pct);
        apb_write(elm_pkg::REG_ENABLE, {31'd0, en});
        apb_write(elm_pkg::REG_LIMIT, {12'd0, lim});
        apb_write(elm_pkg::REG_PCT, {25'd0, pct});
    endtask

    // wait until every expected beat has come back
    task automatic drain;
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_stats.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic push_beat(logic [1:0] k, logic [31:0] t, logic [31:0] f,
                             logic [2:0] s, logic [2:0] a);
        pending_beats.push_back('{k, t, f, s, a});
    endtask

    task automatic push_noise;
        push_beat(2'($urandom_range(0, 3)), $urandom, $urandom,
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    // A lag from a small pool keeps the number of distinct ring values modest
    function automatic logic [31:0] pick_lag;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15) return 32'(($urandom_range(1, 12) * 1237) % (cfg_limit > 1 ? cfg_limit : 2));
        if (sel == 15) return 32'd0;
        if (sel == 16) return 32'(cfg_limit) + $urandom_range(0, 500);
        if (sel == 17) return 32'(cfg_limit) - 1;
        return $urandom_range(1, 1048575);
    endfunction

    // One measurement: tracked event, some clutter, frame end(s), and sometimes a query or spare beat
    task automatic push_measurement;
        logic [31:0] t0, f0;
        logic [2:0]  s, a;
        int          pick;
        t0   = $urandom;
        f0   = $urandom;
        pick = $urandom_range(0, 5);
        case (pick)
            0: begin s = elm_pkg::SRC_LEFT;   a = elm_pkg::ACT_PRESSED; end
            1: begin s = elm_pkg::SRC_RIGHT;  a = elm_pkg::ACT_PRESSED; end
            2: begin s = elm_pkg::SRC_LEFT;   a = elm_pkg::ACT_REPEAT;  end
            3: begin s = elm_pkg::SRC_RIGHT;  a = elm_pkg::ACT_REPEAT;  end
            4: begin s = elm_pkg::SRC_AXIS_X; a = elm_pkg::ACT_AXIS;    end
            default: begin s = elm_pkg::SRC_AXIS_Y; a = elm_pkg::ACT_AXIS; end
        endcase
        push_beat(elm_pkg::KIND_EVENT, t0, f0, s, a);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0: push_beat(elm_pkg::KIND_EOF, t0 + $urandom_range(1, 900),
                             f0 - $urandom_range(0, 2),
                             3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                1: push_beat(elm_pkg::KIND_EVENT, $urandom, $urandom, s, a);
                default: push_beat(KIND_QUERY, $urandom, $urandom,
                                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            endcase
        end
        push_beat(elm_pkg::KIND_EOF, t0 + pick_lag(), f0 + $urandom_range(1, 3),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) == 0)
            push_beat($urandom_range(0, 1) ? KIND_QUERY : KIND_SPARE, $urandom, $urandom,
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    task automatic random_phase(int n_beats);
        int target;
        target = pending_beats.size() + n_beats;
        while (pending_beats.size() < target) begin
            if ($urandom_range(0, 9) < 7) push_measurement();
            else push_noise();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence of the run
    // ---------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled after reset: tracked events must not start anything
        push_beat(elm_pkg::KIND_EVENT, 32'd100, 32'd5, elm_pkg::SRC_LEFT, elm_pkg::ACT_PRESSED);
        push_beat(elm_pkg::KIND_EOF, 32'd200, 32'd6, elm_pkg::SRC_LEFT, elm_pkg::ACT_PRESSED);
        drain();

        set_config(1'b1, 20'd1000000, 7'd95);
        // start, same-frame end (stays pending), then a later frame stores
        push_beat(elm_pkg::KIND_EVENT, 32'd1000, 32'd10, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        push_beat(elm_pkg::KIND_EOF, 32'd1500, 32'd10, SRC_OTHER, ACT_RELEASED);
        push_beat(elm_pkg::KIND_EVENT, 32'd1600, 32'd11, elm_pkg::SRC_RIGHT,
                  elm_pkg::ACT_PRESSED); // ignored, busy
        push_beat(elm_pkg::KIND_EOF, 32'd17000, 32'd11, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        // no measurement waiting: frame end changes nothing
        push_beat(elm_pkg::KIND_EOF, 32'd20000, 32'd12, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        // untracked pairs
        push_beat(elm_pkg::KIND_EVENT, 32'd0, 32'd0, elm_pkg::SRC_LEFT, ACT_RELEASED);
        push_beat(elm_pkg::KIND_EVENT, 32'd0, 32'd0, elm_pkg::SRC_RIGHT, ACT_DOUBLE);
        push_beat(elm_pkg::KIND_EVENT, 32'd0, 32'd0, elm_pkg::SRC_AXIS_X,
                  elm_pkg::ACT_PRESSED);
        push_beat(elm_pkg::KIND_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 3'd7);
        // time wraps across the measurement, frame at the top of its range
        push_beat(elm_pkg::KIND_EVENT, 32'hFFFF_FFF0, 32'hFFFF_FFFE, elm_pkg::SRC_RIGHT,
                  elm_pkg::ACT_REPEAT);
        push_beat(elm_pkg::KIND_EOF, 32'h0000_0020, 32'hFFFF_FFFF, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        // zero lag discarded, pending cleared
        push_beat(elm_pkg::KIND_EVENT, 32'd5000, 32'd40, elm_pkg::SRC_AXIS_X,
                  elm_pkg::ACT_AXIS);
        push_beat(elm_pkg::KIND_EOF, 32'd5000, 32'd41, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        // lag at the limit discarded, one below kept
        push_beat(elm_pkg::KIND_EVENT, 32'd0, 32'd50, elm_pkg::SRC_AXIS_Y, elm_pkg::ACT_AXIS);
        push_beat(elm_pkg::KIND_EOF, 32'd1000000, 32'd51, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        push_beat(elm_pkg::KIND_EVENT, 32'd0, 32'd60, elm_pkg::SRC_LEFT, elm_pkg::ACT_REPEAT);
        push_beat(elm_pkg::KIND_EOF, 32'd999999, 32'd61, elm_pkg::SRC_LEFT,
                  elm_pkg::ACT_PRESSED);
        push_beat(KIND_QUERY, 32'd0, 32'd0, SRC_OTHER, ACT_DOUBLE);
        push_beat(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 3'd7);
        drain();

        // Random phases across register settings, extremes included
        set_config(1'b1, 20'hFFFFF, 7'd100);
        long_hold_asks++;       // receiver holds off while the sender keeps offering
        random_phase(60);
        drain();

        set_config(1'b1, 20'd5000, 7'd1);
        random_phase(50);
        drain();

        set_config(1'b1, 20'd0, 7'd127);    // nothing accepted, percentile clamps
        random_phase(30);
        drain();

        set_config(1'b1, 20'd800000, 7'd0); // rank clamps to the minimum
        random_phase(60);
        drain();

        set_config(1'b0, 20'd1, 7'd50);
        random_phase(20);
        drain();

        set_config(1'b1, 20'd1000000, 7'd95);
        long_hold_asks++;
        random_phase(60);
        drain();

        repeat (TAIL_CYC) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout with a margin of several times the worst case over ~300 beats
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
